>>> rtl/ihl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihl_pkg: shared types and constants of the hex loader parser
// token codes, event codes, parse phases and register indexes
// ---------------------------------------------------------------------------
package ihl_pkg;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_G_LO  = 8'h67;
	localparam logic [7:0] CHAR_G_UP  = 8'h47;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] ALPHA_GAP  = 8'd7;

	localparam logic [7:0]  LPT_RESET   = 8'd32;
	localparam logic [31:0] JUMP_RESET  = 32'h0000_8000;
	localparam logic [31:0] WORD_STRIDE = 32'd4;

	// configuration register indexes
	localparam logic CFG_LINES_PER_TOGGLE = 1'b0;
	localparam logic CFG_JUMP_ADDRESS     = 1'b1;

	// record types
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_SEGMENT = 8'h02;

	typedef enum logic [1:0] {
		TK_COLON = 2'd0,
		TK_EOL   = 2'd1,
		TK_GO    = 2'd2,
		TK_DIGIT = 2'd3
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] nib;
	} token_t;

	typedef enum logic [1:0] {
		EV_WRITE = 2'd0,
		EV_EOF   = 2'd1,
		EV_JUMP  = 2'd2,
		EV_LED   = 2'd3
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [31:0] addr;
		logic [31:0] value;
		logic        led;
	} event_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_CNT0   = 5'd1,
		PH_CNT1   = 5'd2,
		PH_ADR0   = 5'd3,
		PH_ADR1   = 5'd4,
		PH_ADR2   = 5'd5,
		PH_ADR3   = 5'd6,
		PH_TYP0   = 5'd7,
		PH_TYP1   = 5'd8,
		PH_SEG0   = 5'd9,
		PH_SEG1   = 5'd10,
		PH_SEG2   = 5'd11,
		PH_SEG3   = 5'd12,
		PH_SEGEND = 5'd13,
		PH_DAT0   = 5'd14,
		PH_DAT1   = 5'd15,
		PH_DAT2   = 5'd16,
		PH_DAT3   = 5'd17,
		PH_DAT4   = 5'd18,
		PH_DAT5   = 5'd19,
		PH_DAT6   = 5'd20,
		PH_DAT7   = 5'd21
	} phase_t;

	// ascii hex digit to nibble, letters shifted down past the gap
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] adj;
		adj = (c > CHAR_NINE) ? (c - ALPHA_GAP) : c;
		return adj[3:0];
	endfunction

endpackage

>>> rtl/intel_hex_loader_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// intel_hex_loader_parser: hex record parser for a serial boot loader
// classifier, token queue and record engine
// ---------------------------------------------------------------------------
// usage
// - input channel in_valid / in_ready carries one received character per
//   word on rx_char
// - output channel out_valid / out_ready carries one event per word:
//   write word, end of file with sum, jump, or progress led toggle
// - cfg_we / cfg_index / cfg_wdata write lines_per_toggle and jump_address;
//   write only while the parser is idle, the block does not enforce this
// - an accepted character is held in the token queue, and its event is then
//   registered in the event register
// - throughput is one character per cycle if out_ready holds; the engine
//   retires one token per cycle and refills the event register as it drains
// - when the receiver stalls, the engine holds and the queue fills; the
//   input stalls once the queue is full
// - reset clears the parse state, the running sum, the led level and the
//   halt flag, and restores both registers to their defaults
// - after a go character every further character is accepted and dropped
// ---------------------------------------------------------------------------
module intel_hex_loader_parser #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [31:0] word_address,
	output logic [31:0] word_value,
	output logic        led_level,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	import ihl_pkg::*;

	// configuration registers
	logic [7:0]  lines_per_toggle_q;
	logic [31:0] jump_address_q;

	// classifier to queue
	logic   tok_push;
	token_t tok_in;
	logic   tok_room;

	// queue to record engine
	logic   tok_valid;
	token_t tok_out;
	logic   tok_pop;

	// event word from the engine
	logic   ev_valid;
	event_t ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_per_toggle_q <= LPT_RESET;
			jump_address_q     <= JUMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINES_PER_TOGGLE: lines_per_toggle_q <= cfg_wdata[7:0];
				CFG_JUMP_ADDRESS:     jump_address_q     <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	// front: classify characters, halt after go
	ihl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_char  (rx_char),
		.tok_push (tok_push),
		.tok_data (tok_in),
		.tok_room (tok_room)
	);

	// decouples the classifier from the engine
	ihl_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tok_push),
		.push_data (tok_in),
		.room      (tok_room),
		.pop_valid (tok_valid),
		.pop_data  (tok_out),
		.pop       (tok_pop)
	);

	// back: record fields, data words, sum and led progress
	ihl_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.tok_valid        (tok_valid),
		.tok              (tok_out),
		.tok_pop          (tok_pop),
		.lines_per_toggle (lines_per_toggle_q),
		.jump_address     (jump_address_q),
		.ev_valid         (ev_valid),
		.ev               (ev),
		.ev_ready         (out_ready)
	);

	assign out_valid    = ev_valid;
	assign event_kind   = ev.kind;
	assign word_address = ev.addr;
	assign word_value   = ev.value;
	assign led_level    = ev.led;

	// a token never waits in the queue while the engine could take it
	a_engine_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (!out_valid || out_ready)) |-> tok_pop)
		else $error("engine idle with a token waiting");

endmodule

>>> rtl/ihl_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihl_front: character classifier
// turns each received character into a token, drops all input after go
// ---------------------------------------------------------------------------
module ihl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_char,
	output logic            tok_push,
	output ihl_pkg::token_t tok_data,
	input  logic            tok_room
);
	import ihl_pkg::*;

	logic halted_q;
	logic accept;

	assign in_ready = halted_q | tok_room;
	assign accept   = in_valid & in_ready;
	assign tok_push = accept & ~halted_q;

	always_comb begin
		tok_data.nib = nibble_of(rx_char);
		if (rx_char == CHAR_COLON) begin
			tok_data.kind = TK_COLON;
		end else if (rx_char == CHAR_CR || rx_char == CHAR_LF) begin
			tok_data.kind = TK_EOL;
		end else if (rx_char == CHAR_G_LO || rx_char == CHAR_G_UP) begin
			tok_data.kind = TK_GO;
		end else begin
			tok_data.kind = TK_DIGIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (tok_push && tok_data.kind == TK_GO) begin
			halted_q <= 1'b1;
		end
	end

	a_no_push_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !tok_push)
		else $error("token pushed after go");

endmodule

>>> rtl/ihl_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihl_fifo: token queue
// short register queue between classifier and record engine
// ---------------------------------------------------------------------------
module ihl_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ihl_pkg::token_t push_data,
	output logic            room,
	output logic            pop_valid,
	output ihl_pkg::token_t pop_data,
	input  logic            pop
);
	import ihl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign room      = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && room) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && room) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push && room, pop && pop_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue overfilled");

endmodule

>>> rtl/ihl_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihl_back: record engine
// walks the record fields, builds data words and drives the event register
// ---------------------------------------------------------------------------
module ihl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  ihl_pkg::token_t tok,
	output logic            tok_pop,
	input  logic [7:0]      lines_per_toggle,
	input  logic [31:0]     jump_address,
	output logic            ev_valid,
	output ihl_pkg::event_t ev,
	input  logic            ev_ready
);
	import ihl_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  type_hi_q;
	logic [31:0] load_addr_q;
	logic [19:0] seg_base_q;
	logic [31:0] word_q;
	logic [31:0] sum_q;
	logic [7:0]  line_cnt_q;
	logic        led_q;
	logic        ev_valid_q;
	event_t      ev_q, ev_d;
	logic        emit;

	logic        take;
	logic [7:0]  rec_type;
	logic [31:0] gathered;
	logic [31:0] swapped;
	logic [7:0]  line_inc;
	logic        toggle;

	assign take     = tok_valid & (~ev_valid_q | ev_ready);
	assign tok_pop  = take;
	assign rec_type = {type_hi_q, tok.nib};
	assign gathered = {word_q[27:0], tok.nib};
	assign swapped  = {gathered[7:0], gathered[15:8], gathered[23:16], gathered[31:24]};
	assign line_inc = line_cnt_q + 8'd1;
	assign toggle   = (line_inc >= lines_per_toggle);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (tok.kind)
			TK_COLON: phase_d = PH_CNT0;
			TK_EOL:   phase_d = PH_IDLE;
			TK_GO:    phase_d = PH_IDLE;
			TK_DIGIT: begin
				unique case (phase_q)
					PH_IDLE:   phase_d = PH_IDLE;
					PH_CNT0:   phase_d = PH_CNT1;
					PH_CNT1:   phase_d = PH_ADR0;
					PH_ADR0:   phase_d = PH_ADR1;
					PH_ADR1:   phase_d = PH_ADR2;
					PH_ADR2:   phase_d = PH_ADR3;
					PH_ADR3:   phase_d = PH_TYP0;
					PH_TYP0:   phase_d = PH_TYP1;
					PH_TYP1: begin
						priority if (rec_type == REC_DATA) begin
							phase_d = PH_DAT0;
						end else if (rec_type == REC_SEGMENT) begin
							phase_d = PH_SEG0;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_SEG0:   phase_d = PH_SEG1;
					PH_SEG1:   phase_d = PH_SEG2;
					PH_SEG2:   phase_d = PH_SEG3;
					PH_SEG3:   phase_d = PH_SEGEND;
					PH_SEGEND: phase_d = PH_IDLE;
					PH_DAT0:   phase_d = PH_DAT1;
					PH_DAT1:   phase_d = PH_DAT2;
					PH_DAT2:   phase_d = PH_DAT3;
					PH_DAT3:   phase_d = PH_DAT4;
					PH_DAT4:   phase_d = PH_DAT5;
					PH_DAT5:   phase_d = PH_DAT6;
					PH_DAT6:   phase_d = PH_DAT7;
					PH_DAT7:   phase_d = PH_DAT0;
					default:   phase_d = phase_q;
				endcase
			end
			default: phase_d = phase_q;
		endcase
	end

	// event outputs
	always_comb begin
		emit  = 1'b0;
		ev_d  = '{kind: EV_WRITE, addr: 32'd0, value: 32'd0, led: 1'b0};
		unique case (tok.kind)
			TK_COLON: begin
				if (toggle) begin
					emit      = 1'b1;
					ev_d.kind = EV_LED;
					ev_d.led  = ~led_q;
				end
			end
			TK_GO: begin
				emit      = 1'b1;
				ev_d.kind = EV_JUMP;
				ev_d.addr = jump_address;
			end
			TK_DIGIT: begin
				if (phase_q == PH_TYP1 && rec_type == REC_EOF) begin
					emit       = 1'b1;
					ev_d.kind  = EV_EOF;
					ev_d.value = sum_q;
				end else if (phase_q == PH_DAT7) begin
					emit       = 1'b1;
					ev_d.kind  = EV_WRITE;
					ev_d.addr  = load_addr_q;
					ev_d.value = swapped;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			type_hi_q   <= '0;
			load_addr_q <= '0;
			seg_base_q  <= '0;
			word_q      <= '0;
			sum_q       <= '0;
			line_cnt_q  <= '0;
			led_q       <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			if (tok.kind == TK_COLON) begin
				line_cnt_q <= toggle ? 8'd0 : line_inc;
				if (toggle) begin
					led_q <= ~led_q;
				end
			end else if (tok.kind == TK_DIGIT) begin
				unique case (phase_q)
					PH_ADR0, PH_ADR1, PH_ADR2, PH_ADR3: begin
						load_addr_q <= {12'd0, seg_base_q}
							| {16'd0, load_addr_q[11:0], tok.nib};
					end
					PH_TYP0: type_hi_q <= tok.nib;
					PH_SEG0, PH_SEG1, PH_SEG2, PH_SEG3: begin
						seg_base_q <= {4'd0, seg_base_q[11:0], tok.nib};
					end
					PH_SEGEND: seg_base_q <= {seg_base_q[15:0], 4'd0};
					PH_DAT0, PH_DAT1, PH_DAT2, PH_DAT3,
					PH_DAT4, PH_DAT5, PH_DAT6: word_q <= gathered;
					PH_DAT7: begin
						word_q      <= swapped;
						sum_q       <= sum_q + load_addr_q + swapped;
						load_addr_q <= load_addr_q + WORD_STRIDE;
					end
					default: ;
				endcase
			end
		end
	end

	// output register, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (take) begin
			ev_valid_q <= emit;
		end else if (ev_ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_q <= ev_d;
		end
	end

	assign ev_valid = ev_valid_q;
	assign ev       = ev_q;

	a_word_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.kind == TK_DIGIT && phase_q == PH_DAT7)
		|=> (ev_valid_q && ev_q.kind == EV_WRITE && phase_q == PH_DAT0))
		else $error("eighth data digit gave no write");

	a_eol_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.kind == TK_EOL) |=> (phase_q == PH_IDLE && !ev_valid_q))
		else $error("line end did not return to idle");

endmodule
